// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table package
// Shared constants, command and status codes, controller states and the
// control word that the controller broadcasts along the chain of cells.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int TIME_BITS        = 34;
   localparam int DATE_SHIFT       = 11;
   localparam int TAG_PORT_BITS    = 32;
   localparam int CHOICE_BITS      = 7;
   localparam int COUNT_BITS       = 7;
   localparam int DEPTH_DEFAULT    = 32;
   localparam int TAG_BITS_DEFAULT = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_RETAG  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_COMPACT,
      ST_REPLY
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE,
      CELL_COMPACT
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic                 phase;
      logic [TIME_BITS-1:0] key;
   } cell_ctl_type;

endpackage

// File: rtl/sorted_timestamp_table.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table
// A chain of DEPTH cells kept in timestamp order, driven by one controller.
// ----------------------------------------------------------------------------
// An insert runs its insert step and then its reply, or goes straight to the reply
// on a full table; query and retag scan the whole chain, and remove scans it and
// then compacts it, and stalls can hold any of them. One command is in the block
// at a time and the next beat is taken in the cycle after the final result is
// registered.
// Reset clears the valid bit of every cell and the control state.
module sorted_timestamp_table #(
   parameter int DEPTH    = stt_pkg::DEPTH_DEFAULT,
   parameter int TAG_BITS = stt_pkg::TAG_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_day,
   input  logic [3:0]  req_month,
   input  logic [13:0] req_year,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [31:0] req_tag_in,
   input  logic [6:0]  req_choice,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_out_day,
   output logic [3:0]  rsp_out_month,
   output logic [13:0] rsp_out_year,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [31:0] rsp_tag_out,
   output logic [6:0]  rsp_removed_count,
   output logic        rsp_last
);
   import stt_pkg::*;

   // Stored tag bits: the tag port is 32 bits wide.
   localparam int TW = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;

   cell_ctl_type         ctl;
   logic [TW-1:0]        new_tag;
   logic                 tail_valid;
   logic [TIME_BITS-1:0] tail_time;
   logic [TW-1:0]        tail_tag;
   logic [TIME_BITS-1:0] req_time;
   logic [TIME_BITS-1:0] rsp_time;

   logic                 c_valid [DEPTH];
   logic                 c_gt    [DEPTH];
   logic [TIME_BITS-1:0] c_time  [DEPTH];
   logic [TW-1:0]        c_tag   [DEPTH];

   assign req_time = {req_year, req_month, req_day, req_hour, req_minute};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 p_valid, p_gt, n_valid;
      logic [TIME_BITS-1:0] p_time, n_time;
      logic [TW-1:0]        p_tag, n_tag;

      if (i == 0) begin : g_head
         // The head sees a settled entry before it that is never later.
         assign p_valid = 1'b1;
         assign p_gt    = 1'b0;
         assign p_time  = '0;
         assign p_tag   = '0;
      end else begin : g_body
         assign p_valid = c_valid[i-1];
         assign p_gt    = c_gt[i-1];
         assign p_time  = c_time[i-1];
         assign p_tag   = c_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_valid = tail_valid;
         assign n_time  = tail_time;
         assign n_tag   = tail_tag;
      end else begin : g_next
         assign n_valid = c_valid[i+1];
         assign n_time  = c_time[i+1];
         assign n_tag   = c_tag[i+1];
      end

      stt_cell #(
         .TW  (TW),
         .ODD (i % 2 == 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_tag    (new_tag),
         .prev_valid (p_valid),
         .prev_gt    (p_gt),
         .prev_time  (p_time),
         .prev_tag   (p_tag),
         .next_valid (n_valid),
         .next_time  (n_time),
         .next_tag   (n_tag),
         .ent_valid  (c_valid[i]),
         .ent_time   (c_time[i]),
         .ent_tag    (c_tag[i]),
         .ent_gt     (c_gt[i])
      );
   end

   stt_ctrl #(
      .DEPTH (DEPTH),
      .TW    (TW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_time    (req_time),
      .req_tag_in  (req_tag_in),
      .req_choice  (req_choice),
      .head_valid  (c_valid[0]),
      .head_time   (c_time[0]),
      .head_tag    (c_tag[0]),
      .table_full  (c_valid[DEPTH-1]),
      .ctl         (ctl),
      .new_tag     (new_tag),
      .tail_valid  (tail_valid),
      .tail_time   (tail_time),
      .tail_tag    (tail_tag),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_time    (rsp_time),
      .rsp_tag     (rsp_tag_out),
      .rsp_removed (rsp_removed_count),
      .rsp_last    (rsp_last)
   );

   assign rsp_out_year   = rsp_time[33:20];
   assign rsp_out_month  = rsp_time[19:16];
   assign rsp_out_day    = rsp_time[15:11];
   assign rsp_out_hour   = rsp_time[10:6];
   assign rsp_out_minute = rsp_time[5:0];

endmodule

// File: rtl/stt_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one entry of the sorted table and exchanges it with its neighbours:
// sorted insert, rotation towards the head, and odd-even compaction of holes.
// ----------------------------------------------------------------------------
module stt_cell #(
   parameter int TW  = 32,
   parameter bit ODD = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stt_pkg::cell_ctl_type         ctl,
   input  logic [TW-1:0]                 new_tag,
   input  logic                          prev_valid,
   input  logic                          prev_gt,
   input  logic [stt_pkg::TIME_BITS-1:0] prev_time,
   input  logic [TW-1:0]                 prev_tag,
   input  logic                          next_valid,
   input  logic [stt_pkg::TIME_BITS-1:0] next_time,
   input  logic [TW-1:0]                 next_tag,
   output logic                          ent_valid,
   output logic [stt_pkg::TIME_BITS-1:0] ent_time,
   output logic [TW-1:0]                 ent_tag,
   output logic                          ent_gt
);
   import stt_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TW-1:0]        tag_ff, tag_in;
   logic                 is_left;

   assign ent_gt  = valid_ff && (time_ff > ctl.key);
   assign is_left = (ctl.phase == ODD);

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      tag_in   = tag_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            // Entries later than the new one move one place down the chain.
            if (prev_gt) begin
               valid_in = prev_valid;
               time_in  = prev_time;
               tag_in   = prev_tag;
            end else if (prev_valid && (ent_gt || !valid_ff)) begin
               valid_in = 1'b1;
               time_in  = ctl.key;
               tag_in   = new_tag;
            end
         end
         CELL_ROTATE: begin
            valid_in = next_valid;
            time_in  = next_time;
            tag_in   = next_tag;
         end
         CELL_COMPACT: begin
            // A hole and a live entry to its right swap places.
            if (is_left) begin
               if (!valid_ff && next_valid) begin
                  valid_in = 1'b1;
                  time_in  = next_time;
                  tag_in   = next_tag;
               end
            end else if (!prev_valid && valid_ff) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign ent_valid = valid_ff;
   assign ent_time  = time_ff;
   assign ent_tag   = tag_ff;

endmodule

// File: rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Table controller
// Takes commands, sequences the cell chain through insert, rotation and
// compaction, watches the head cell and forms the result beats.
// ----------------------------------------------------------------------------
module stt_ctrl #(
   parameter int DEPTH = 32,
   parameter int TW    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [stt_pkg::TIME_BITS-1:0]     req_time,
   input  logic [stt_pkg::TAG_PORT_BITS-1:0] req_tag_in,
   input  logic [stt_pkg::CHOICE_BITS-1:0]   req_choice,
   input  logic                              head_valid,
   input  logic [stt_pkg::TIME_BITS-1:0]     head_time,
   input  logic [TW-1:0]                     head_tag,
   input  logic                              table_full,
   output stt_pkg::cell_ctl_type             ctl,
   output logic [TW-1:0]                     new_tag,
   output logic                              tail_valid,
   output logic [stt_pkg::TIME_BITS-1:0]     tail_time,
   output logic [TW-1:0]                     tail_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [stt_pkg::TIME_BITS-1:0]     rsp_time,
   output logic [stt_pkg::TAG_PORT_BITS-1:0] rsp_tag,
   output logic [stt_pkg::COUNT_BITS-1:0]    rsp_removed,
   output logic                              rsp_last
);
   import stt_pkg::*;

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff;
   logic [TIME_BITS-1:0] key_ff;
   logic [TW-1:0]        tag_ff;
   logic [CHOICE_BITS-1:0] choice_ff;
   logic                 full_ff;
   logic [SW-1:0]        step_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 held_valid_ff;
   logic [TIME_BITS-1:0] held_time_ff;
   logic [TW-1:0]        held_tag_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [TIME_BITS-1:0] rsp_time_ff;
   logic [TAG_PORT_BITS-1:0] rsp_tag_ff;
   logic [COUNT_BITS-1:0] rsp_removed_ff;
   logic                 rsp_last_ff;

   logic                 accept, out_free, last_step;
   logic                 hit_date, hit_exact, hit, step_go;
   logic [COUNT_BITS-1:0] cnt_wide, cnt_plus;
   logic                 emit;
   status_type           em_status;
   logic [TIME_BITS-1:0] em_time;
   logic [TAG_PORT_BITS-1:0] em_tag;
   logic [COUNT_BITS-1:0] em_removed;
   logic                 em_last;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (step_ff == SW'(DEPTH - 1));
   assign hit_date  = head_valid &&
                      (head_time[TIME_BITS-1:DATE_SHIFT] == key_ff[TIME_BITS-1:DATE_SHIFT]);
   assign hit_exact = head_valid && (head_time == key_ff);
   assign hit       = (cmd_ff == CMD_RETAG) ? hit_exact : hit_date;
   assign cnt_wide  = COUNT_BITS'(cnt_ff);
   assign cnt_plus  = cnt_wide + COUNT_BITS'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (cmd_type'(req_cmd) == CMD_INSERT) begin
                  state_in = table_full ? ST_REPLY : ST_INSERT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_INSERT: begin
            state_in = ST_REPLY;
         end
         ST_SCAN: begin
            if (step_go && last_step) begin
               state_in = (cmd_ff == CMD_REMOVE) ? ST_COMPACT : ST_REPLY;
            end
         end
         ST_COMPACT: begin
            if (last_step) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      ctl.op     = CELL_HOLD;
      ctl.phase  = step_ff[0];
      ctl.key    = key_ff;
      tail_valid = 1'b0;
      tail_time  = head_time;
      tail_tag   = head_tag;
      step_go    = 1'b0;
      emit       = 1'b0;
      em_status  = STATUS_OK;
      em_time    = '0;
      em_tag     = '0;
      em_removed = '0;
      em_last    = 1'b1;
      unique case (state_ff)
         ST_INSERT: begin
            ctl.op = CELL_INSERT;
         end
         ST_SCAN: begin
            // A second query hit can only be taken once the held one has left.
            step_go = !((cmd_ff == CMD_QUERY) && hit && held_valid_ff && !out_free);
            ctl.op  = step_go ? CELL_ROTATE : CELL_HOLD;
            tail_valid = head_valid && !((cmd_ff == CMD_REMOVE) && hit);
            if ((cmd_ff == CMD_RETAG) && hit && (cnt_plus == choice_ff)) begin
               tail_tag = tag_ff;
            end
            if ((cmd_ff == CMD_QUERY) && hit && held_valid_ff && step_go) begin
               emit    = 1'b1;
               em_time = held_time_ff;
               em_tag  = TAG_PORT_BITS'(held_tag_ff);
               em_last = 1'b0;
            end
         end
         ST_COMPACT: begin
            ctl.op  = CELL_COMPACT;
            step_go = 1'b1;
         end
         ST_REPLY: begin
            emit = out_free;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  em_status = full_ff ? STATUS_FULL : STATUS_OK;
               end
               CMD_REMOVE: begin
                  em_status  = (cnt_ff == '0) ? STATUS_NONE : STATUS_OK;
                  em_removed = cnt_wide;
               end
               CMD_QUERY: begin
                  if (held_valid_ff) begin
                     em_time = held_time_ff;
                     em_tag  = TAG_PORT_BITS'(held_tag_ff);
                  end else begin
                     em_status = STATUS_NONE;
                  end
               end
               CMD_RETAG: begin
                  if (cnt_ff == '0) begin
                     em_status = STATUS_NONE;
                  end else if ((choice_ff == '0) || (choice_ff > cnt_wide)) begin
                     em_status = STATUS_RANGE;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign new_tag = tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            held_valid_ff <= 1'b0;
         end else if ((state_ff == ST_SCAN) && step_go && hit && (cmd_ff == CMD_QUERY)) begin
            held_valid_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(req_cmd);
         key_ff    <= req_time;
         tag_ff    <= req_tag_in[TW-1:0];
         choice_ff <= req_choice;
         full_ff   <= table_full;
         step_ff   <= '0;
         cnt_ff    <= '0;
      end else if (step_go) begin
         step_ff <= last_step ? '0 : step_ff + SW'(1);
         if ((state_ff == ST_SCAN) && hit && (cmd_ff != CMD_QUERY)) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
      if ((state_ff == ST_SCAN) && step_go && hit && (cmd_ff == CMD_QUERY)) begin
         held_time_ff <= head_time;
         held_tag_ff  <= head_tag;
      end
      if (emit) begin
         rsp_status_ff  <= em_status;
         rsp_time_ff    <= em_time;
         rsp_tag_ff     <= em_tag;
         rsp_removed_ff <= em_removed;
         rsp_last_ff    <= em_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_time    = rsp_time_ff;
   assign rsp_tag     = rsp_tag_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// File: rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table checker
// Watches the ports of the table and flags result beats that break its rules.
// ----------------------------------------------------------------------------
module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [13:0] rsp_out_year,
   input logic [31:0] rsp_tag_out,
   input logic [6:0]  rsp_removed_count,
   input logic        rsp_last
);
   import stt_pkg::*;

   // A waiting result beat is held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_tag_out) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // Every failing command gives exactly one beat, so it is the last one.
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last &&
      (rsp_out_year == '0) && (rsp_tag_out == '0))
      else $error("failure beat not final or carries data");

   // A removal count only appears on a successful, final remove beat.
   a_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_removed_count != '0) |-> rsp_last &&
      (rsp_status == STATUS_OK) && (rsp_tag_out == '0))
      else $error("removal count on a wrong beat");

   // After reset the table is empty-handed and ready for a command.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind sorted_timestamp_table stt_checker u_stt_checker (.*);

// File: test/tb_sorted_timestamp_table.sv
// ----------------------------------------------------------------------------
// Sorted timestamp table testbench
// Sends insert, remove, query and retag commands over the request channel
// under random idling on both sides. A local copy of the table predicts
// every result beat, and the result channel is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_timestamp_table;
   import stt_pkg::*;

   localparam int DEPTH    = DEPTH_DEFAULT;
   localparam int TAG_BITS = TAG_BITS_DEFAULT;
   localparam logic [31:0] TAG_MASK =
      (TAG_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TAG_BITS) - 64'd1);

   typedef struct {
      status_type  status;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [31:0] tag;
      logic [6:0]  removed;
      logic        last;
   } table_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_INSERT;
   logic [4:0]  req_day = '0;
   logic [3:0]  req_month = '0;
   logic [13:0] req_year = '0;
   logic [4:0]  req_hour = '0;
   logic [5:0]  req_minute = '0;
   logic [31:0] req_tag_in = '0;
   logic [6:0]  req_choice = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_out_day;
   logic [3:0]  rsp_out_month;
   logic [13:0] rsp_out_year;
   logic [4:0]  rsp_out_hour;
   logic [5:0]  rsp_out_minute;
   logic [31:0] rsp_tag_out;
   logic [6:0]  rsp_removed_count;
   logic        rsp_last;

   // Local copy of the table, advanced at each accepted request beat.
   logic [TIME_BITS-1:0] stored_time [DEPTH];
   logic [31:0]          stored_tag [DEPTH];
   int                   stored_count = 0;

   table_reply_type awaited_replies[$];
   int  mismatch_count = 0;
   int  req_idle_pct = 0;
   int  rsp_stall_pct = 0;
   logic hold_rsp = 1'b0;

   sorted_timestamp_table #(
      .DEPTH(DEPTH),
      .TAG_BITS(TAG_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_day(req_day),
      .req_month(req_month),
      .req_year(req_year),
      .req_hour(req_hour),
      .req_minute(req_minute),
      .req_tag_in(req_tag_in),
      .req_choice(req_choice),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_day(rsp_out_day),
      .rsp_out_month(rsp_out_month),
      .rsp_out_year(rsp_out_year),
      .rsp_out_hour(rsp_out_hour),
      .rsp_out_minute(rsp_out_minute),
      .rsp_tag_out(rsp_tag_out),
      .rsp_removed_count(rsp_removed_count),
      .rsp_last(rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [TIME_BITS-1:0] stamp(int year, int month, int day,
                                                  int hour, int minute);
      return {14'(year), 4'(month), 5'(day), 5'(hour), 6'(minute)};
   endfunction

   function automatic void push_reply(status_type status, logic [TIME_BITS-1:0] t,
                                      logic [31:0] tag, int removed, logic last);
      table_reply_type r;
      r.status  = status;
      r.year    = t[33:20];
      r.month   = t[19:16];
      r.day     = t[15:11];
      r.hour    = t[10:6];
      r.minute  = t[5:0];
      r.tag     = tag;
      r.removed = 7'(removed);
      r.last    = last;
      awaited_replies.push_back(r);
   endfunction

   function automatic void apply_table_command(cmd_type op, logic [TIME_BITS-1:0] t,
                                               logic [31:0] tag, logic [6:0] choice);
      int i;
      int pos;
      int w;
      int hits;
      int seen;
      logic [TIME_BITS-1-DATE_SHIFT:0] date;
      date = t[TIME_BITS-1:DATE_SHIFT];
      hits = 0;
      seen = 0;
      case (op)
         CMD_INSERT: begin
            if (stored_count >= DEPTH) begin
               push_reply(STATUS_FULL, '0, '0, 0, 1'b1);
            end else begin
               // Equal timestamps keep arrival order: the new entry goes after them.
               pos = 0;
               while (pos < stored_count && stored_time[pos] <= t) pos++;
               for (i = stored_count; i > pos; i--) begin
                  stored_time[i] = stored_time[i-1];
                  stored_tag[i]  = stored_tag[i-1];
               end
               stored_time[pos] = t;
               stored_tag[pos]  = tag & TAG_MASK;
               stored_count++;
               push_reply(STATUS_OK, '0, '0, 0, 1'b1);
            end
         end
         CMD_REMOVE: begin
            w = 0;
            for (i = 0; i < stored_count; i++) begin
               if (stored_time[i][TIME_BITS-1:DATE_SHIFT] == date) begin
                  hits++;
               end else begin
                  stored_time[w] = stored_time[i];
                  stored_tag[w]  = stored_tag[i];
                  w++;
               end
            end
            stored_count = w;
            push_reply(hits != 0 ? STATUS_OK : STATUS_NONE, '0, '0, hits, 1'b1);
         end
         CMD_QUERY: begin
            for (i = 0; i < stored_count; i++)
               if (stored_time[i][TIME_BITS-1:DATE_SHIFT] == date) hits++;
            if (hits == 0) push_reply(STATUS_NONE, '0, '0, 0, 1'b1);
            for (i = 0; i < stored_count; i++) begin
               if (stored_time[i][TIME_BITS-1:DATE_SHIFT] == date) begin
                  seen++;
                  push_reply(STATUS_OK, stored_time[i], stored_tag[i], 0, seen == hits);
               end
            end
         end
         default: begin
            for (i = 0; i < stored_count; i++)
               if (stored_time[i] == t) hits++;
            if (hits == 0) begin
               push_reply(STATUS_NONE, '0, '0, 0, 1'b1);
            end else if (choice == 0 || int'(choice) > hits) begin
               push_reply(STATUS_RANGE, '0, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < stored_count; i++) begin
                  if (stored_time[i] == t) begin
                     seen++;
                     if (seen == int'(choice)) stored_tag[i] = tag & TAG_MASK;
                  end
               end
               push_reply(STATUS_OK, '0, '0, 0, 1'b1);
            end
         end
      endcase
   endfunction

   // Offers one request beat and returns at the edge that accepts it, with
   // valid still high so that a following beat can go out back to back.
   task automatic send_command(cmd_type op, logic [TIME_BITS-1:0] t,
                               logic [31:0] tag, logic [6:0] choice);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= op;
      req_year   <= t[33:20];
      req_month  <= t[19:16];
      req_day    <= t[15:11];
      req_hour   <= t[10:6];
      req_minute <= t[5:0];
      req_tag_in <= tag;
      req_choice <= choice;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_table_command(op, t, tag, choice);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      logic [TIME_BITS-1:0] top_stamp;
      top_stamp = stamp(9999, 12, 31, 23, 59);
      // On an empty table every lookup reports that nothing was found.
      send_command(CMD_QUERY, stamp(0, 1, 1, 0, 0), 32'd0, 7'd0);
      send_command(CMD_REMOVE, stamp(0, 1, 1, 0, 0), 32'd0, 7'd0);
      send_command(CMD_RETAG, stamp(0, 1, 1, 0, 0), 32'd5, 7'd1);
      send_command(CMD_INSERT, stamp(0, 1, 1, 0, 0), 32'd0, 7'd0);
      send_command(CMD_INSERT, top_stamp, 32'hFFFF_FFFF, 7'd0);
      // Values beyond the calendar ranges are stored as raw bits.
      send_command(CMD_INSERT, stamp(16383, 15, 31, 31, 63), 32'hA5A5_5A5A, 7'h7F);
      send_command(CMD_INSERT, stamp(0, 0, 0, 0, 0), 32'd1, 7'd0);
      send_command(CMD_INSERT, top_stamp, 32'd2, 7'd0);
      send_command(CMD_INSERT, top_stamp, 32'd3, 7'd0);
      send_command(CMD_RETAG, top_stamp, 32'hDEAD_BEEF, 7'd0);
      send_command(CMD_RETAG, top_stamp, 32'hDEAD_BEEF, 7'd4);
      send_command(CMD_RETAG, top_stamp, 32'hDEAD_BEEF, 7'h7F);
      send_command(CMD_RETAG, top_stamp, 32'h1234_5678, 7'd2);
      send_command(CMD_RETAG, top_stamp, 32'h0, 7'd3);
      send_command(CMD_RETAG, stamp(9999, 12, 31, 23, 58), 32'h1, 7'd1);
      send_command(CMD_QUERY, top_stamp, 32'd0, 7'd0);
      send_command(CMD_QUERY, stamp(16383, 15, 31, 0, 0), 32'd0, 7'd0);
      send_command(CMD_REMOVE, top_stamp, 32'd0, 7'd0);
      send_command(CMD_QUERY, top_stamp, 32'd0, 7'd0);
      send_command(CMD_QUERY, stamp(0, 0, 0, 0, 0), 32'd0, 7'd0);
      wait_for_replies();
   endtask

   // The receiver holds off while inserts keep coming, so the block backs up
   // and stalls its input; the table is filled past its depth on one date.
   task automatic test_backpressure();
      logic [TIME_BITS-1-DATE_SHIFT:0] fill_date;
      int fill_items;
      int k;
      fill_date = {14'($urandom_range(9999)), 4'($urandom_range(1, 12)),
                   5'($urandom_range(1, 31))};
      fill_items = DEPTH - stored_count + 2;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat ($urandom_range(300, 500)) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (k = 0; k < fill_items; k++)
         send_command(CMD_INSERT, {fill_date, 5'($urandom_range(2)), 6'($urandom_range(2))},
                      $urandom, 7'($urandom));
      send_command(CMD_QUERY, {fill_date, 11'($urandom)}, $urandom, 7'($urandom));
      wait_for_replies();
      send_command(CMD_REMOVE, {fill_date, 11'($urandom)}, $urandom, 7'($urandom));
      wait_for_replies();
   endtask

   task automatic test_random_traffic(int items, int send_pct, int stall_pct);
      logic [TIME_BITS-1-DATE_SHIFT:0] dates [4];
      logic [DATE_SHIFT-1:0]           clocks [3];
      logic [TIME_BITS-1:0]            t;
      logic [6:0]                      choice;
      int n;
      int pick;
      int idx;
      int hits;
      int i;
      req_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
      for (n = 0; n < items; n++) begin
         // A small pool of dates and times makes matches and exact duplicates common.
         if (n % 40 == 0) begin
            foreach (dates[j])
               dates[j] = {14'($urandom_range(9999)), 4'($urandom_range(1, 12)),
                           5'($urandom_range(1, 31))};
            foreach (clocks[j])
               clocks[j] = {5'($urandom_range(23)), 6'($urandom_range(59))};
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_command(cmd_type'($urandom_range(3)), TIME_BITS'({$urandom, $urandom}),
                         $urandom, 7'($urandom));
         end else if (pick < 50) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5:
                  t = {dates[$urandom_range(3)], clocks[$urandom_range(2)]};
               6, 7, 8:
                  t = {dates[$urandom_range(3)], 5'($urandom_range(23)),
                       6'($urandom_range(59))};
               default:
                  t = TIME_BITS'({$urandom, $urandom});
            endcase
            send_command(CMD_INSERT, t, $urandom, 7'($urandom));
         end else if (pick < 85) begin
            if (stored_count > 0 && $urandom_range(9) < 6) begin
               idx = $urandom_range(stored_count - 1);
               t = {stored_time[idx][TIME_BITS-1:DATE_SHIFT], 11'($urandom)};
            end else begin
               t = {dates[$urandom_range(3)], 11'($urandom)};
            end
            send_command(pick < 65 ? CMD_REMOVE : CMD_QUERY, t, $urandom, 7'($urandom));
         end else begin
            if (stored_count > 0 && $urandom_range(9) < 8) begin
               idx = $urandom_range(stored_count - 1);
               t = stored_time[idx];
               hits = 0;
               for (i = 0; i < stored_count; i++)
                  if (stored_time[i] == t) hits++;
               choice = 7'($urandom_range(hits + 1));
            end else begin
               t = {dates[$urandom_range(3)], clocks[$urandom_range(2)]};
               choice = 7'($urandom_range(3));
            end
            send_command(CMD_RETAG, t, $urandom, choice);
         end
      end
      wait_for_replies();
   endtask

   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $error("result beat arrived with no result awaited");
            mismatch_count++;
         end else begin
            want = awaited_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("out_day", want.day, rsp_out_day);
            check_field("out_month", want.month, rsp_out_month);
            check_field("out_year", want.year, rsp_out_year);
            check_field("out_hour", want.hour, rsp_out_hour);
            check_field("out_minute", want.minute, rsp_out_minute);
            check_field("tag_out", want.tag, rsp_tag_out);
            check_field("removed_count", want.removed, rsp_removed_count);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(125, 34, 78);
      test_backpressure();
      test_random_traffic(125, 78, 34);
      test_random_traffic(125, 0, 0);
      wait_for_replies();
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/stt_pkg.sv
rtl/stt_cell.sv
rtl/stt_ctrl.sv
rtl/sorted_timestamp_table.sv
rtl/stt_checker.sv
test/tb_sorted_timestamp_table.sv
